// ===== rtl/two_channel_lux_calculator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-channel lux calculator
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef TWO_CHANNEL_LUX_CALCULATOR_CORE_MACROS_SVH
`define TWO_CHANNEL_LUX_CALCULATOR_CORE_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define TLC_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define TLC_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== rtl/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// Types, constants and the power table of the two-channel lux calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package tlc_pkg;

    localparam int CNT_W               = 16;
    localparam int ITIME_W             = 16;
    localparam int LUX_W               = 32;
    localparam int CFG_W               = 16;
    localparam int CFG_IDX_W           = 1;
    localparam int RATIO_FRACTION_BITS = 16;
    localparam int POWER_TABLE_ENTRIES = 64;

    localparam int SPAN       = 2 * POWER_TABLE_ENTRIES;
    localparam int SPAN_SHIFT = $clog2(SPAN);
    localparam int IDX_SHIFT  = RATIO_FRACTION_BITS - SPAN_SHIFT;
    localparam int IDX_W      = SPAN_SHIFT - 1;
    localparam int ROM_IDX_W  = $clog2(POWER_TABLE_ENTRIES + 1);
    localparam int POW_W      = 16;
    localparam int ROM_DEN    = SPAN * 4096;

    // Widths through the back end.
    localparam int PROD_W = CNT_W + RATIO_FRACTION_BITS + 2;
    localparam int TERM_W = 30;
    localparam int D_W    = 47;
    localparam int NUM_W  = 60;
    localparam int Q_W    = NUM_W - 24;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CNT_W-1:0] SAT_COUNT = 16'hFFFF;
    localparam logic [ITIME_W-1:0] ITIME_RESET = 16'd402;
    localparam logic [8:0] NORM_MS = 9'd402;
    localparam int LOW_GAIN_SHIFT = 4;

    localparam logic [RATIO_FRACTION_BITS:0] BP_061 = (RATIO_FRACTION_BITS + 1)'(
        ((64'd61 << RATIO_FRACTION_BITS) + 64'd50) / 64'd100);
    localparam logic [RATIO_FRACTION_BITS:0] BP_080 = (RATIO_FRACTION_BITS + 1)'(
        ((64'd80 << RATIO_FRACTION_BITS) + 64'd50) / 64'd100);
    localparam logic [RATIO_FRACTION_BITS:0] BP_130 = (RATIO_FRACTION_BITS + 1)'(
        ((64'd130 << RATIO_FRACTION_BITS) + 64'd50) / 64'd100);

    // Q16 coefficients of the lux formula.
    localparam logic [11:0] C1A = 12'd1992;
    localparam logic [11:0] C1B = 12'd4063;
    localparam logic [11:0] C2A = 12'd1468;
    localparam logic [11:0] C2B = 12'd2032;
    localparam logic [11:0] C3A = 12'd839;
    localparam logic [11:0] C3B = 12'd1003;
    localparam logic [11:0] C4A = 12'd96;
    localparam logic [11:0] C4B = 12'd73;
    localparam logic [TERM_W-1:0] C1A_Q16 = TERM_W'(C1A) << 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITIME = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_SAT   = 2'd1,
        STAT_ITIME = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_POW  = 3'd1,
        KIND_R2   = 3'd2,
        KIND_R3   = 3'd3,
        KIND_R4   = 3'd4
    } kind_t;

    typedef struct packed {
        logic               gain_high;
        logic [ITIME_W-1:0] integration_ms;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]   bb;
        logic [CNT_W-1:0]   ir;
        logic               gain_high;
        logic [ITIME_W-1:0] ims;
        stat_t              status;
        kind_t              kind;
        logic               live;
    } item_t;

    typedef logic [POW_W-1:0] pow_rom_t [0:POWER_TABLE_ENTRIES];

    // t^1.4 in Q16 at t = k/SPAN, built from the Q12 fifth root of q^2.
    function automatic pow_rom_t build_pow_rom();
        pow_rom_t rom;
        logic [63:0] q;
        logic [63:0] v;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        logic [63:0] num;
        int k;
        for (k = 0; k <= POWER_TABLE_ENTRIES; k++)
        begin
            q  = (64'(k) << 30) / SPAN;
            v  = q * q;
            lo = 64'd0;
            hi = 64'd4096;
            while (lo < hi)
            begin
                mid = (lo + hi + 64'd1) / 2;
                p   = mid * mid * mid * mid * mid;
                if (p <= v)
                    lo = mid;
                else
                    hi = mid - 64'd1;
            end
            num    = (64'(k) * lo) << 16;
            rom[k] = POW_W'((num + 64'(ROM_DEN / 2)) / ROM_DEN);
        end
        return rom;
    endfunction

    localparam pow_rom_t POW_ROM = build_pow_rom();

endpackage

`default_nettype wire

// ===== rtl/two_channel_lux_calculator_core.sv =====
// ----------------------------------------------------------------------------
// two_channel_lux_calculator_core
// Lux from a broadband and an infrared photodiode count, Q24.8 result.
// ----------------------------------------------------------------------------
// Usage:
// A sample pair (broadband_count, infrared_count) transfers on the input
// channel when in_valid is high and in_stall is low. One result (lux_q8,
// status) transfers on the output channel for every sample, in order, when
// out_valid is high and out_stall is low.
// gain_high and integration_ms are written through cfg_write_en, cfg_index
// and cfg_data while no sample is in flight; each sample takes the values
// present when it transfers in.
// From the input transfer to out_valid a sample passes one input register,
// one queue slot, 16 ratio divider stages, 6 interpolation and formula
// stages, 36 normalizing divider stages and the output register. One
// sample is taken per cycle while in_stall is low; in_stall depends on the
// input register and the four-entry queue.
// With out_valid and out_stall high the back-end pipeline holds; the queue
// then fills and in_stall rises once it and the input register are full.
// Reset clears all pipeline valids, empties the queue and sets gain_high to
// 0 and integration_ms to 402.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_channel_lux_calculator_core_macros.svh"

module two_channel_lux_calculator_core
    import tlc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [CNT_W-1:0]     broadband_count,
    input  wire logic [CNT_W-1:0]     infrared_count,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [LUX_W-1:0]          lux_q8,
    output logic [1:0]                status,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic               gain_reg;
    logic [ITIME_W-1:0] ims_reg;
    cfg_t               cfg;
    logic               push;
    item_t              push_item;
    logic               pop;
    logic               fifo_full;
    logic               fifo_empty;
    item_t              head;

    assign cfg.gain_high      = gain_reg;
    assign cfg.integration_ms = ims_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= 1'b0;
            ims_reg  <= ITIME_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_GAIN:  gain_reg <= cfg_data[0];
                CFG_ITIME: ims_reg  <= cfg_data[ITIME_W-1:0];
                default:   ;
            endcase
        end
    end

    tlc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .broadband_count (broadband_count),
        .infrared_count  (infrared_count),
        .cfg             (cfg),
        .fifo_full       (fifo_full),
        .push            (push),
        .push_item       (push_item)
    );

    tlc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (fifo_full),
        .empty     (fifo_empty),
        .head      (head)
    );

    tlc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (fifo_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .lux_q8    (lux_q8),
        .status    (status)
    );

    `TLC_ASSERT_SAME(a_error_lux_zero, out_valid && status != STAT_OK, lux_q8 == '0, "error status with nonzero lux")
    `TLC_ASSERT_NEXT(a_gain_write, cfg_write_en && cfg_index == CFG_GAIN, gain_reg == $past(cfg_data[0]), "gain write lost")
    `TLC_ASSERT_NEXT(a_itime_write, cfg_write_en && cfg_index == CFG_ITIME, ims_reg == $past(cfg_data), "integration time write lost")

endmodule

`default_nettype wire

// ===== rtl/tlc_front.sv =====
// ----------------------------------------------------------------------------
// tlc_front
// Input register: takes a sample pair and sorts it into its formula region.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_front
    import tlc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [CNT_W-1:0] broadband_count,
    input  wire logic [CNT_W-1:0] infrared_count,
    input  wire cfg_t             cfg,
    input  wire logic             fifo_full,
    output logic                  push,
    output item_t                 push_item
);

    logic              valid_reg;
    item_t             item_reg;
    item_t             item_next;
    logic              accept;
    logic [PROD_W-1:0] ir_sh;
    logic [PROD_W-1:0] lim_061;
    logic [PROD_W-1:0] lim_080;
    logic [PROD_W-1:0] lim_130;

    assign push      = valid_reg && !fifo_full;
    assign in_stall  = valid_reg && fifo_full;
    assign accept    = in_valid && !in_stall;
    assign push_item = item_reg;

    // The ratio is compared against each breakpoint by cross multiplication.
    assign ir_sh   = PROD_W'(infrared_count) << RATIO_FRACTION_BITS;
    assign lim_061 = PROD_W'(BP_061) * PROD_W'(broadband_count);
    assign lim_080 = PROD_W'(BP_080) * PROD_W'(broadband_count);
    assign lim_130 = PROD_W'(BP_130) * PROD_W'(broadband_count);

    always_comb
    begin
        item_next.bb        = broadband_count;
        item_next.ir        = infrared_count;
        item_next.gain_high = cfg.gain_high;
        item_next.ims       = cfg.integration_ms;
        item_next.status    = STAT_OK;
        item_next.kind      = KIND_NONE;
        item_next.live      = 1'b0;
        if (broadband_count == SAT_COUNT || infrared_count == SAT_COUNT)
        begin
            item_next.status = STAT_SAT;
        end
        else if (cfg.integration_ms == '0)
        begin
            item_next.status = STAT_ITIME;
        end
        else if (broadband_count != '0)
        begin
            item_next.live = 1'b1;
            if ((CNT_W + 1)'(infrared_count) << 1 < (CNT_W + 1)'(broadband_count))
                item_next.kind = KIND_POW;
            else if (ir_sh < lim_061)
                item_next.kind = KIND_R2;
            else if (ir_sh < lim_080)
                item_next.kind = KIND_R3;
            else if (ir_sh < lim_130)
                item_next.kind = KIND_R4;
            else
                item_next.live = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (push)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

endmodule

`default_nettype wire

// ===== rtl/tlc_fifo.sv =====
// ----------------------------------------------------------------------------
// tlc_fifo
// Short queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_fifo
    import tlc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output logic       full,
    output logic       empty,
    output item_t      head
);

    item_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    assign full  = count_reg == FIFO_CNT_W'(FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ===== rtl/tlc_back.sv =====
// ----------------------------------------------------------------------------
// tlc_back
// Pipelined ratio divider, power interpolation, formula and normalizing divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_back
    import tlc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  empty,
    input  wire item_t head,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic [LUX_W-1:0] lux_q8,
    output logic [1:0] status
);

    localparam int RD = RATIO_FRACTION_BITS;

    logic adv;

    // Ratio divider stages.
    logic                           rd_valid_reg [1:RD];
    item_t                          rd_item_reg  [1:RD];
    logic [CNT_W-1:0]               rd_rem_reg   [1:RD];
    logic [RATIO_FRACTION_BITS-1:0] rd_q_reg     [1:RD];

    // Interpolation and formula stages.
    logic                           p1_valid_reg;
    item_t                          p1_item_reg;
    logic [POW_W-1:0]               p1_ya_reg;
    logic [POW_W-1:0]               p1_diff_reg;
    logic [RATIO_FRACTION_BITS-1:0] p1_f_reg;
    logic                           p2_valid_reg;
    item_t                          p2_item_reg;
    logic [POW_W-1:0]               p2_ya_reg;
    logic [POW_W+RATIO_FRACTION_BITS-1:0] p2_prod_reg;
    logic                           p3_valid_reg;
    item_t                          p3_item_reg;
    logic [POW_W-1:0]               p3_p_reg;
    logic                           p4_valid_reg;
    item_t                          p4_item_reg;
    logic signed [TERM_W-1:0]       p4_term_reg;
    logic                           p5_valid_reg;
    item_t                          p5_item_reg;
    logic signed [D_W-1:0]          p5_d_reg;
    logic                           p6_valid_reg;
    item_t                          p6_item_reg;
    logic [Q_W-1:0]                 p6_m_reg;

    // Normalizing divider stages; the quotient shifts in as the dividend shifts out.
    logic               dq_valid_reg [1:Q_W];
    item_t              dq_item_reg  [1:Q_W];
    logic [ITIME_W-1:0] dq_rem_reg   [1:Q_W];
    logic [Q_W-1:0]     dq_mq_reg    [1:Q_W];

    logic             out_valid_reg;
    logic [LUX_W-1:0] lux_reg;
    stat_t            status_reg;

    logic [RATIO_FRACTION_BITS-1:0] r;
    logic [IDX_W-1:0]               idx;
    logic [POW_W-1:0]               ya_next;
    logic [POW_W-1:0]               yb_next;
    logic [TERM_W-1:0]              term_next;
    logic signed [D_W-1:0]          d_next;
    item_t                          p5_item_next;
    logic [D_W-2:0]                 d_pos;
    logic [NUM_W-1:0]               num_next;
    logic [NUM_W-1:0]               sum_next;
    logic [Q_W-1:0]                 q_last;
    logic [LUX_W-1:0]               lux_next;

    assign adv       = !out_valid_reg || !out_stall;
    assign pop       = adv && !empty;
    assign out_valid = out_valid_reg;
    assign lux_q8    = lux_reg;
    assign status    = status_reg;

    for (genvar s = 0; s < RD; s++)
    begin : g_rd
        logic                           v_in;
        item_t                          it_in;
        logic [CNT_W-1:0]               rem_in;
        logic [RATIO_FRACTION_BITS-1:0] q_in;
        logic [CNT_W:0]                 t;
        logic                           ge;
        logic [CNT_W-1:0]               rem_next;

        if (s == 0)
        begin : g_first
            always_comb
            begin
                v_in   = !empty;
                it_in  = head;
                rem_in = head.ir;
                q_in   = '0;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                v_in   = rd_valid_reg[s];
                it_in  = rd_item_reg[s];
                rem_in = rd_rem_reg[s];
                q_in   = rd_q_reg[s];
            end
        end

        always_comb
        begin
            t        = {rem_in, 1'b0};
            ge       = t >= {1'b0, it_in.bb};
            rem_next = ge ? CNT_W'(t - {1'b0, it_in.bb}) : CNT_W'(t);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rd_valid_reg[s+1] <= 1'b0;
            else if (adv)
                rd_valid_reg[s+1] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rd_item_reg[s+1] <= it_in;
                rd_rem_reg[s+1]  <= rem_next;
                rd_q_reg[s+1]    <= {q_in[RATIO_FRACTION_BITS-2:0], ge};
            end
        end
    end

    // Table index and fraction of the interpolation.
    always_comb
    begin
        r       = rd_q_reg[RD];
        idx     = IDX_W'(r >> IDX_SHIFT);
        ya_next = POW_ROM[ROM_IDX_W'(idx)];
        yb_next = POW_ROM[ROM_IDX_W'(idx) + 1'b1];
    end

    always_comb
    begin
        unique case (p3_item_reg.kind)
            KIND_POW:
                term_next = C1A_Q16 - TERM_W'(C1B) * TERM_W'(p3_p_reg);
            KIND_R2:
                term_next = TERM_W'(C2A) * TERM_W'(p3_item_reg.bb)
                          - TERM_W'(C2B) * TERM_W'(p3_item_reg.ir);
            KIND_R3:
                term_next = TERM_W'(C3A) * TERM_W'(p3_item_reg.bb)
                          - TERM_W'(C3B) * TERM_W'(p3_item_reg.ir);
            KIND_R4:
                term_next = TERM_W'(C4A) * TERM_W'(p3_item_reg.bb)
                          - TERM_W'(C4B) * TERM_W'(p3_item_reg.ir);
            default:
                term_next = '0;
        endcase
    end

    always_comb
    begin
        p5_item_next = p4_item_reg;
        if (p4_item_reg.kind == KIND_POW)
            d_next = $signed(D_W'({1'b0, p4_item_reg.bb})) * D_W'(p4_term_reg);
        else
            d_next = D_W'(p4_term_reg) <<< 16;
        if (d_next <= 0)
            p5_item_next.live = 1'b0;
    end

    // Rounded scale by 402 * gain / integration time, shifted down by 24.
    always_comb
    begin
        d_pos    = p5_d_reg[D_W-2:0];
        num_next = NUM_W'(d_pos) * NUM_W'(NORM_MS);
        if (!p5_item_reg.gain_high)
            num_next = num_next << LOW_GAIN_SHIFT;
        sum_next = num_next + (NUM_W'(p5_item_reg.ims) << 23);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= rd_valid_reg[RD];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            p6_valid_reg <= p5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_item_reg <= rd_item_reg[RD];
            p1_ya_reg   <= ya_next;
            p1_diff_reg <= (yb_next >= ya_next) ? yb_next - ya_next : '0;
            p1_f_reg    <= {r[IDX_SHIFT-1:0], SPAN_SHIFT'(0)};
            p2_item_reg <= p1_item_reg;
            p2_ya_reg   <= p1_ya_reg;
            p2_prod_reg <= (POW_W + RATIO_FRACTION_BITS)'(p1_diff_reg)
                         * (POW_W + RATIO_FRACTION_BITS)'(p1_f_reg);
            p3_item_reg <= p2_item_reg;
            p3_p_reg    <= p2_ya_reg
                         + p2_prod_reg[POW_W+RATIO_FRACTION_BITS-1:RATIO_FRACTION_BITS];
            p4_item_reg <= p3_item_reg;
            p4_term_reg <= $signed(term_next);
            p5_item_reg <= p5_item_next;
            p5_d_reg    <= d_next;
            p6_item_reg <= p5_item_reg;
            p6_m_reg    <= sum_next[NUM_W-1:NUM_W-Q_W];
        end
    end

    for (genvar s = 0; s < Q_W; s++)
    begin : g_dq
        logic               v_in;
        item_t              it_in;
        logic [ITIME_W-1:0] rem_in;
        logic [Q_W-1:0]     mq_in;
        logic [ITIME_W:0]   t;
        logic               ge;
        logic [ITIME_W-1:0] rem_next;

        if (s == 0)
        begin : g_first
            always_comb
            begin
                v_in   = p6_valid_reg;
                it_in  = p6_item_reg;
                rem_in = '0;
                mq_in  = p6_m_reg;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                v_in   = dq_valid_reg[s];
                it_in  = dq_item_reg[s];
                rem_in = dq_rem_reg[s];
                mq_in  = dq_mq_reg[s];
            end
        end

        always_comb
        begin
            t        = {rem_in, mq_in[Q_W-1]};
            ge       = t >= {1'b0, it_in.ims};
            rem_next = ge ? ITIME_W'(t - {1'b0, it_in.ims}) : ITIME_W'(t);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dq_valid_reg[s+1] <= 1'b0;
            else if (adv)
                dq_valid_reg[s+1] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dq_item_reg[s+1] <= it_in;
                dq_rem_reg[s+1]  <= rem_next;
                dq_mq_reg[s+1]   <= {mq_in[Q_W-2:0], ge};
            end
        end
    end

    always_comb
    begin
        q_last = dq_mq_reg[Q_W];
        if (!dq_item_reg[Q_W].live)
            lux_next = '0;
        else if (q_last[Q_W-1:LUX_W] != '0)
            lux_next = '1;
        else
            lux_next = q_last[LUX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dq_valid_reg[Q_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lux_reg    <= lux_next;
            status_reg <= dq_item_reg[Q_W].status;
        end
    end

endmodule

`default_nettype wire
